/* rtl/ccc_pkg.sv */
// package for the (26,16) cyclic code corrector
// holds code constants, the single-bit syndrome table, status codes and stage structs
// no dependencies
`timescale 1ns / 1ps

package ccc_pkg;

    localparam int CODE_BITS  = 26;
    localparam int CHECK_BITS = 10;
    localparam int DATA_BITS  = CODE_BITS - CHECK_BITS;
    localparam logic [CHECK_BITS:0] GEN_POLY = 11'h5B9;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_FAIL   = 2'd3
    } status_t;

    typedef logic [CHECK_BITS-1:0] syn_t;
    typedef syn_t syn_tbl_t [CODE_BITS];

    // remainder of x^pos divided by g(x), worked out at elaboration
    function automatic syn_t syn_of_bit(input int pos);
        logic [CODE_BITS-1:0] v;
        v = '0;
        v[pos] = 1'b1;
        for (int b = CODE_BITS - 1; b >= CHECK_BITS; b--)
        begin
            if (v[b])
            begin
                v = v ^ (CODE_BITS'(GEN_POLY) << (b - CHECK_BITS));
            end
        end
        return v[CHECK_BITS-1:0];
    endfunction

    function automatic syn_tbl_t build_syn_tbl();
        syn_tbl_t t;
        for (int p = 0; p < CODE_BITS; p++)
        begin
            t[p] = syn_of_bit(p);
        end
        return t;
    endfunction

    // entry p is the syndrome of an error at codeword bit p
    localparam syn_tbl_t SYN_TBL = build_syn_tbl();

    typedef struct packed {
        logic [CODE_BITS-1:0] codeword;
        syn_t                 syndrome;
    } syn_stage_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]                 data;
        logic                                 syn_zero;
        logic [CODE_BITS-1:0]                 single_hit;
        logic [CODE_BITS-1:0][CODE_BITS-1:0]  pair_hit;
    } match_stage_t;

endpackage

/* rtl/ccc_word_if.sv */
// input channel of the corrector: valid/ready with one 26-bit codeword
// depends on ccc_pkg for widths
`timescale 1ns / 1ps

interface ccc_word_if;
    logic                           valid;
    logic                           ready;
    logic [ccc_pkg::CODE_BITS-1:0]  codeword;

    modport source (output valid, output codeword, input ready);
    modport sink (input valid, input codeword, output ready);
endinterface

/* rtl/ccc_result_if.sv */
// output channel of the corrector: valid/ready with data word and status
// depends on ccc_pkg for widths
`timescale 1ns / 1ps

interface ccc_result_if;
    logic                           valid;
    logic                           ready;
    logic [ccc_pkg::DATA_BITS-1:0]  data_word;
    logic [1:0]                     status;

    modport source (output valid, output data_word, output status, input ready);
    modport sink (input valid, input data_word, input status, output ready);
endinterface

/* rtl/ccc_syn_stage.sv */
// first stage: registers the codeword with its syndrome
// depends on ccc_pkg
`timescale 1ns / 1ps

module ccc_syn_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ccc_pkg::CODE_BITS-1:0]  in_codeword,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ccc_pkg::syn_stage_t            out_stage
);
    import ccc_pkg::*;

    logic       valid_reg;
    syn_stage_t stage_reg;
    syn_t       syn_next;

    // syndrome is linear: xor of the columns of set bits
    always_comb
    begin
        syn_next = '0;
        for (int p = 0; p < CODE_BITS; p++)
        begin
            if (in_codeword[p])
            begin
                syn_next = syn_next ^ SYN_TBL[p];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_reg.codeword <= in_codeword;
            stage_reg.syndrome <= syn_next;
        end
    end

endmodule

/* rtl/ccc_match_stage.sv */
// second stage: compares the syndrome against every single-bit and two-bit pattern
// depends on ccc_pkg
`timescale 1ns / 1ps

module ccc_match_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ccc_pkg::syn_stage_t    in_stage,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ccc_pkg::match_stage_t  out_stage
);
    import ccc_pkg::*;

    logic         valid_reg;
    match_stage_t stage_reg;
    match_stage_t stage_next;

    always_comb
    begin
        stage_next.data     = in_stage.codeword[CODE_BITS-1:CHECK_BITS];
        stage_next.syn_zero = (in_stage.syndrome == '0);
        for (int p = 0; p < CODE_BITS; p++)
        begin
            stage_next.single_hit[p] = (in_stage.syndrome == SYN_TBL[p]);
            for (int q = 0; q < CODE_BITS; q++)
            begin
                // only pairs with p above q are candidates
                stage_next.pair_hit[p][q] = (q < p) &&
                    ((in_stage.syndrome ^ SYN_TBL[p]) == SYN_TBL[q]);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

/* rtl/ccc_select_stage.sv */
// last stage: picks one matching pattern, flips its data bits, registers the result
// depends on ccc_pkg
`timescale 1ns / 1ps

module ccc_select_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ccc_pkg::match_stage_t           in_stage,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ccc_pkg::DATA_BITS-1:0]   out_data_word,
    output logic [1:0]                      out_status
);
    import ccc_pkg::*;

    localparam int POS_W = $clog2(CODE_BITS);

    logic                   valid_reg;
    logic [DATA_BITS-1:0]   data_reg;
    status_t                status_reg;
    logic [DATA_BITS-1:0]   data_next;
    status_t                status_next;

    logic [CODE_BITS-1:0]   row_any;
    logic [POS_W-1:0]       single_pos;
    logic [POS_W-1:0]       pair_p;
    logic [POS_W-1:0]       pair_q;
    logic [CODE_BITS-1:0]   pair_row;
    logic [CODE_BITS-1:0]   flip;

    // ascending scans so the highest set position wins
    always_comb
    begin
        single_pos = '0;
        pair_p     = '0;
        for (int p = 0; p < CODE_BITS; p++)
        begin
            row_any[p] = |in_stage.pair_hit[p];
            if (in_stage.single_hit[p])
            begin
                single_pos = POS_W'(p);
            end
            if (row_any[p])
            begin
                pair_p = POS_W'(p);
            end
        end
        pair_row = in_stage.pair_hit[pair_p];
        pair_q   = '0;
        for (int q = 0; q < CODE_BITS; q++)
        begin
            if (pair_row[q])
            begin
                pair_q = POS_W'(q);
            end
        end
    end

    always_comb
    begin
        flip = '0;
        if (in_stage.syn_zero)
        begin
            status_next = ST_NONE;
        end
        else if (|in_stage.single_hit)
        begin
            status_next      = ST_SINGLE;
            flip[single_pos] = 1'b1;
        end
        else if (|row_any)
        begin
            status_next  = ST_DOUBLE;
            flip[pair_p] = 1'b1;
            flip[pair_q] = 1'b1;
        end
        else
        begin
            status_next = ST_FAIL;
        end
        data_next = in_stage.data ^ flip[CODE_BITS-1:CHECK_BITS];
    end

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_data_word = data_reg;
    assign out_status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    a_clean_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_stage.syn_zero |=> status_reg == ST_NONE)
        else $error("clean word not reported as clean");

    a_clean_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_stage.syn_zero |=> data_reg == $past(in_stage.data))
        else $error("clean word data altered");

    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_stage.syn_zero && (|in_stage.single_hit)
        |=> status_reg == ST_SINGLE)
        else $error("single-bit match not reported as single correction");

    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_stage.syn_zero && !(|in_stage.single_hit)
        && !(|row_any) |=> status_reg == ST_FAIL && data_reg == $past(in_stage.data))
        else $error("uncorrectable word not passed through raw");

endmodule

/* rtl/cyclic_code_26_16_corrector.sv */
// top level of the (26,16) cyclic code corrector
// depends on ccc_pkg, ccc_word_if, ccc_result_if and the three stage modules
`timescale 1ns / 1ps

// Corrects one 26-bit word of the (26,16) shortened cyclic code with generator 0x5B9
// (data in bits 25..10) and returns the 16 data bits with a status: 0 clean, 1 single
// bit corrected, 2 two bits corrected, 3 uncorrectable (raw data passed through).
// A single-bit pattern beats a two-bit one; among candidates of one kind the one at
// the highest bit positions wins. The block takes one word per clock while the result
// side accepts, and holds three registered stages: syndrome, pattern compare against
// all single and two-bit error syndromes, then selection and output register. A word
// passes the syndrome, match and select registers in turn before its result is valid;
// result-side stalls hold the pipeline; stages that hold no word still take new ones.

module cyclic_code_26_16_corrector (
    input  logic          clk,
    input  logic          rst_n,
    ccc_word_if.sink      word,
    ccc_result_if.source  result
);
    import ccc_pkg::*;

    logic         syn_valid;
    logic         syn_ready;
    syn_stage_t   syn_stage;
    logic         match_valid;
    logic         match_ready;
    match_stage_t match_stage;

    ccc_syn_stage u_syn (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (word.valid),
        .in_ready    (word.ready),
        .in_codeword (word.codeword),
        .out_valid   (syn_valid),
        .out_ready   (syn_ready),
        .out_stage   (syn_stage)
    );

    ccc_match_stage u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (syn_valid),
        .in_ready  (syn_ready),
        .in_stage  (syn_stage),
        .out_valid (match_valid),
        .out_ready (match_ready),
        .out_stage (match_stage)
    );

    ccc_select_stage u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (match_valid),
        .in_ready      (match_ready),
        .in_stage      (match_stage),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_data_word (result.data_word),
        .out_status    (result.status)
    );

endmodule
